FILE: rtl/smc_pkg.sv
// Shared types and constants for the speech frame mouth classifier.
`default_nettype none
package smc_pkg;

  // Frame classes, as shown on the result channel
  typedef enum logic [1:0] {
    ST_CLOSED   = 2'd0,
    ST_OPEN     = 2'd1,
    ST_SIBILANT = 2'd2
  } mouth_t;

  // Configuration register set
  typedef struct packed {
    logic signed [15:0] silence_level;
    logic [16:0]        crossing_threshold;
    logic [15:0]        hf_threshold;
    logic [15:0]        hold_time_ms;
  } cfg_t;

  // Configuration port geometry and register indexes
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 17;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SILENCE  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CROSSING = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HF       = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD     = 4'd3;

  // Register reset values
  localparam logic signed [15:0] SILENCE_RESET  = -16'sd11520;
  localparam logic [16:0]        CROSSING_RESET = 17'd16384;
  localparam logic [15:0]        HF_RESET       = 16'd16384;
  localparam logic [15:0]        HOLD_RESET     = 16'd120;

  // Arithmetic constants
  localparam logic [15:0] DB_FLOOR_Q8       = 16'd30720;  // 120 dB in Q8.8
  localparam logic [17:0] DB_PER_OCTAVE_Q16 = 18'd197283; // 10*log10(2) in Q16
  localparam logic [15:0] HF_SAT            = 16'd32768;  // 2.0 in Q2.14
  localparam int          HF_NORM_BITS      = 40;
  localparam int          MANT_BITS         = 31;
  localparam int          FRAC_BITS         = 16;
  localparam int          HF_QUOT_BITS      = 31;

endpackage
`default_nettype wire

FILE: rtl/smc_fifo.sv
// Small register queue that carries frame records from front to back end.
`default_nettype none
module smc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("frame queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("frame queue underflow");

endmodule
`default_nettype wire

FILE: rtl/smc_front.sv
// Front end: takes samples, accumulates frame sums and queues a record per frame.
`default_nettype none
module smc_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_MAX   = 1024,
  localparam int CW = $clog2(FRAME_MAX + 1),
  localparam int EW = 2 * SAMPLE_BITS - 1 + CW,
  localparam int DW = 2 * SAMPLE_BITS + CW + 1,
  localparam int RW = EW + DW + 2 * CW + 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          sample_bad,
  input  wire logic                          frame_last,
  input  wire logic [31:0]                   timestamp_ms,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [RW-1:0]                      q_data
);

  logic [EW-1:0]                   energy_sum;
  logic [DW-1:0]                   diff_energy_sum;
  logic [CW-1:0]                   crossing_count;
  logic [CW-1:0]                   frame_count;
  logic signed [SAMPLE_BITS-1:0]   previous_sample;
  logic                            previous_valid;

  logic                            accept;
  logic signed [2*SAMPLE_BITS-1:0] sq_e;
  logic signed [SAMPLE_BITS:0]     df;
  logic signed [2*SAMPLE_BITS+1:0] sq_d;
  logic                            pair;
  logic [CW-1:0]                   count_next;
  logic                            frame_end;
  logic [EW-1:0]                   energy_next;
  logic [DW-1:0]                   diff_next;
  logic [CW-1:0]                   crossing_next;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // per-sample squares
  assign sq_e = sample * sample;
  assign df   = {sample[SAMPLE_BITS-1], sample}
              - {previous_sample[SAMPLE_BITS-1], previous_sample};
  assign sq_d = df * df;
  assign pair = !sample_bad && previous_valid;

  // accumulator updates
  assign count_next    = frame_count + 1'b1;
  assign frame_end     = frame_last || (count_next == CW'(FRAME_MAX));
  assign energy_next   = sample_bad ? energy_sum
                       : energy_sum + {{(EW-2*SAMPLE_BITS){1'b0}}, sq_e};
  assign diff_next     = pair ? diff_energy_sum
                              + {{(DW-2*SAMPLE_BITS-2){1'b0}}, sq_d}
                       : diff_energy_sum;
  assign crossing_next = (pair && (sample[SAMPLE_BITS-1] != previous_sample[SAMPLE_BITS-1]))
                       ? crossing_count + 1'b1 : crossing_count;

  // frame record out
  assign q_push = accept && frame_end;
  assign q_data = {timestamp_ms, count_next, crossing_next, diff_next, energy_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum      <= '0;
      diff_energy_sum <= '0;
      crossing_count  <= '0;
      frame_count     <= '0;
      previous_valid  <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        energy_sum      <= '0;
        diff_energy_sum <= '0;
        crossing_count  <= '0;
        frame_count     <= '0;
        previous_valid  <= 1'b0;
      end else begin
        energy_sum      <= energy_next;
        diff_energy_sum <= diff_next;
        crossing_count  <= crossing_next;
        frame_count     <= count_next;
        previous_valid  <= !sample_bad;
      end
    end
  end

  // last good sample, only meaningful while previous_valid is set
  always_ff @(posedge clk) begin
    if (accept && !sample_bad) begin
      previous_sample <= sample;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/smc_back.sv
// Back end: per-frame level, crossing rate, HF ratio, classification and hold.
`default_nettype none
module smc_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_MAX   = 1024,
  localparam int CW = $clog2(FRAME_MAX + 1),
  localparam int EW = 2 * SAMPLE_BITS - 1 + CW,
  localparam int DW = 2 * SAMPLE_BITS + CW + 1,
  localparam int RW = EW + DW + 2 * CW + 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire smc_pkg::cfg_t      cfg,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire logic [RW-1:0]      q_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      level_db,
  output logic [16:0]             crossing_rate,
  output logic [15:0]             hf_ratio,
  output logic [1:0]              instant_state,
  output logic [1:0]              shown_state
);

  localparam int MB   = smc_pkg::MANT_BITS;
  localparam int FB   = smc_pkg::FRAC_BITS;
  localparam int QB   = smc_pkg::HF_QUOT_BITS;
  localparam int LW   = (EW > MB) ? EW : MB;
  localparam int KW   = $clog2(LW);
  localparam int TW   = KW + 18;
  localparam int PW   = TW + 18;
  localparam int NW   = CW + 17;
  localparam int NCW  = $clog2(NW + 1);
  localparam int HW   = smc_pkg::HF_NORM_BITS;
  localparam int AW   = HW + CW;
  localparam logic [TW-1:0] LOG_OFFS = TW'(2 * (SAMPLE_BITS - 1)) << FB;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG_E, S_NORM, S_SQ, S_MUL, S_LEVEL, S_RATE_START, S_RATE_DIV,
    S_HF_START, S_HF_SHIFT, S_HF_MUL, S_HF_CHECK, S_HF_DIV, S_SQRT, S_CLASS
  } state_t;

  state_t state;

  // frame record
  logic [EW-1:0] e_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] c_r;
  logic [CW-1:0] n_r;
  logic [31:0]   ts_r;
  logic [CW-1:0] nm1;

  // log unit
  logic [LW-1:0]    lx;
  logic [KW-1:0]    lk;
  logic [MB-1:0]    lm;
  logic [FB-1:0]    lfrac;
  logic [3:0]       lcnt;
  logic             lsel;
  logic [KW+FB-1:0] le;
  logic [TW-1:0]    t_r;
  logic [PW-1:0]    prod;

  // crossing-rate divider
  logic [CW:0]   drem;
  logic [NW-1:0] dq;
  logic [NCW-1:0] dcnt;

  // hf ratio path
  logic [DW-1:0]  dsh;
  logic [EW-1:0]  esh;
  logic [AW-1:0]  ha;
  logic [AW-1:0]  hb;
  logic [AW+1:0]  hrem;
  logic [QB-1:0]  hq;
  logic [4:0]     hcnt;
  logic [31:0]    sq_q;
  logic [31:0]    sq_res;
  logic [31:0]    sq_bit;

  // frame results
  logic signed [15:0] level_r;
  logic [16:0]        rate_r;
  logic [15:0]        hf_r;
  smc_pkg::mouth_t    held;
  logic [31:0]        last_change_time;

  // combinational helpers
  logic [2*MB-1:0]  msq;
  logic [MB:0]      msh;
  logic             lbit;
  logic [MB-1:0]    lm_next;
  logic [FB-1:0]    lfrac_next;
  logic [TW-1:0]    ln_total;
  logic [TW-1:0]    t_val;
  logic [PW-1:0]    mag_w;
  logic [15:0]      mag16;
  logic [CW+1:0]    dtrial;
  logic             dfit;
  logic [CW:0]      drem_next;
  logic [NW-1:0]    dq_next;
  logic             big;
  logic [AW+1:0]    hb4;
  logic [AW+2:0]    hcand;
  logic             hfit;
  logic [AW+1:0]    hrem_next;
  logic [QB-1:0]    hq_next;
  logic [31:0]      sq_sum;
  logic             sq_ge;
  logic [31:0]      sq_res_next;
  smc_pkg::mouth_t  inst;
  smc_pkg::mouth_t  held_next;
  logic [31:0]      lct_next;
  logic [31:0]      elapsed;
  logic             out_free;

  assign nm1   = n_r - 1'b1;
  assign q_pop = (state == S_IDLE) && !q_empty;

  // mantissa squaring step of the log unit
  assign msq        = {{MB{1'b0}}, lm} * {{MB{1'b0}}, lm};
  assign msh        = msq[2*MB-1:MB-1];
  assign lbit       = msh[MB];
  assign lm_next    = lbit ? msh[MB:1] : msh[MB-1:0];
  assign lfrac_next = {lfrac[FB-2:0], lbit};
  assign ln_total   = TW'({lk, lfrac_next}) + LOG_OFFS;
  assign t_val      = (ln_total > TW'(le)) ? ln_total - TW'(le) : '0;

  // rounding and saturation of the dB magnitude
  assign mag_w = (prod + (PW'(1) << 23)) >> 24;
  assign mag16 = (mag_w > PW'(smc_pkg::DB_FLOOR_Q8)) ? smc_pkg::DB_FLOOR_Q8 : mag_w[15:0];

  // restoring divider step for the crossing rate
  assign dtrial    = {drem, dq[NW-1]};
  assign dfit      = dtrial >= (CW+2)'(nm1);
  assign drem_next = dfit ? (CW+1)'(dtrial - (CW+2)'(nm1)) : dtrial[CW:0];
  assign dq_next   = {dq[NW-2:0], dfit};

  // hf normalization and ratio division step
  assign big       = ((dsh >> HW) != '0) || ((esh >> HW) != '0);
  assign hb4       = {hb, 2'b00};
  assign hcand     = (hcnt == '0) ? (AW+3)'(hrem) : {hrem, 1'b0};
  assign hfit      = hcand >= (AW+3)'(hb4);
  assign hrem_next = hfit ? (AW+2)'(hcand - (AW+3)'(hb4)) : (AW+2)'(hcand);
  assign hq_next   = {hq[QB-2:0], hfit};

  // integer square root step
  assign sq_sum      = sq_res + sq_bit;
  assign sq_ge       = sq_q >= sq_sum;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  // classification and hold smoothing
  assign elapsed  = ts_r - last_change_time;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (level_r < cfg.silence_level) begin
      inst = smc_pkg::ST_CLOSED;
    end else if (rate_r >= cfg.crossing_threshold && hf_r >= cfg.hf_threshold) begin
      inst = smc_pkg::ST_SIBILANT;
    end else begin
      inst = smc_pkg::ST_OPEN;
    end
    held_next = held;
    lct_next  = last_change_time;
    priority if (inst != smc_pkg::ST_CLOSED) begin
      held_next = inst;
      lct_next  = ts_r;
    end else if (held != smc_pkg::ST_CLOSED) begin
      if (ts_r < last_change_time) begin
        lct_next = ts_r;
      end else if (elapsed >= {16'd0, cfg.hold_time_ms}) begin
        held_next = smc_pkg::ST_CLOSED;
        lct_next  = ts_r;
      end
    end
  end

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      held             <= smc_pkg::ST_CLOSED;
      last_change_time <= '0;
    end else begin
      // in S_CLASS the result register is reloaded instead
      if (out_valid && !out_stall && state != S_CLASS) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            e_r   <= q_data[EW-1:0];
            d_r   <= q_data[EW +: DW];
            c_r   <= q_data[EW+DW +: CW];
            n_r   <= q_data[EW+DW+CW +: CW];
            ts_r  <= q_data[RW-1 -: 32];
            state <= S_LOG_E;
          end
        end
        S_LOG_E: begin
          if (e_r == '0) begin
            level_r <= -$signed(smc_pkg::DB_FLOOR_Q8);
            state   <= S_RATE_START;
          end else begin
            lx    <= LW'(e_r);
            lk    <= KW'(LW - 1);
            lsel  <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (lx[LW-1]) begin
            lm    <= lx[LW-1 -: MB];
            lfrac <= '0;
            lcnt  <= '0;
            state <= S_SQ;
          end else begin
            lx <= lx << 1;
            lk <= lk - 1'b1;
          end
        end
        S_SQ: begin
          lm    <= lm_next;
          lfrac <= lfrac_next;
          lcnt  <= lcnt + 1'b1;
          if (lcnt == 4'd15) begin
            if (!lsel) begin
              le    <= {lk, lfrac_next};
              lx    <= LW'(n_r);
              lk    <= KW'(LW - 1);
              lsel  <= 1'b1;
              state <= S_NORM;
            end else begin
              t_r   <= t_val;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= PW'(t_r) * PW'(smc_pkg::DB_PER_OCTAVE_Q16);
          state <= S_LEVEL;
        end
        S_LEVEL: begin
          level_r <= $signed(16'd0 - mag16);
          state   <= S_RATE_START;
        end
        S_RATE_START: begin
          if (n_r < CW'(2)) begin
            rate_r <= '0;
            state  <= S_HF_START;
          end else begin
            dq    <= (NW'(c_r) << 16) + NW'(nm1 >> 1);
            drem  <= '0;
            dcnt  <= '0;
            state <= S_RATE_DIV;
          end
        end
        S_RATE_DIV: begin
          drem <= drem_next;
          dq   <= dq_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == NCW'(NW - 1)) begin
            rate_r <= dq_next[16:0];
            state  <= S_HF_START;
          end
        end
        S_HF_START: begin
          if (n_r < CW'(2)) begin
            hf_r  <= '0;
            state <= S_CLASS;
          end else if (e_r == '0) begin
            hf_r  <= (d_r != '0) ? smc_pkg::HF_SAT : 16'd0;
            state <= S_CLASS;
          end else begin
            dsh   <= d_r;
            esh   <= e_r;
            state <= S_HF_SHIFT;
          end
        end
        S_HF_SHIFT: begin
          if (big) begin
            dsh <= dsh >> 1;
            esh <= esh >> 1;
          end else begin
            state <= S_HF_MUL;
          end
        end
        S_HF_MUL: begin
          ha    <= AW'(HW'(dsh)) * AW'(n_r);
          hb    <= AW'(HW'(esh)) * AW'(nm1);
          state <= S_HF_CHECK;
        end
        S_HF_CHECK: begin
          if (ha == '0) begin
            hf_r  <= '0;
            state <= S_CLASS;
          end else if (hb == '0 || (AW+2)'(ha) > hb4) begin
            hf_r  <= smc_pkg::HF_SAT;
            state <= S_CLASS;
          end else begin
            hrem  <= (AW+2)'(ha);
            hq    <= '0;
            hcnt  <= '0;
            state <= S_HF_DIV;
          end
        end
        S_HF_DIV: begin
          hrem <= hrem_next;
          hq   <= hq_next;
          hcnt <= hcnt + 1'b1;
          if (hcnt == 5'(QB - 1)) begin
            sq_q   <= 32'(hq_next);
            sq_res <= '0;
            sq_bit <= 32'd1 << 30;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_q <= sq_q - sq_sum;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            hf_r  <= (sq_res_next > 32'(smc_pkg::HF_SAT)) ? smc_pkg::HF_SAT
                   : sq_res_next[15:0];
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (out_free) begin
            held             <= held_next;
            last_change_time <= lct_next;
            level_db         <= level_r;
            crossing_rate    <= rate_r;
            hf_ratio         <= hf_r;
            instant_state    <= inst;
            shown_state      <= held_next;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_shown_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && instant_state != smc_pkg::ST_CLOSED |-> shown_state == instant_state)
    else $error("shown state does not follow a non-closed frame");
  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    state == S_SQ |-> lm[MB-1])
    else $error("log mantissa not normalized");
  a_hf_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_HF_DIV |-> hrem <= hb4)
    else $error("ratio divider remainder out of range");
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_CLASS && out_valid && out_stall |=> state == S_CLASS)
    else $error("result dropped while output is stalled");

endmodule
`default_nettype wire

FILE: rtl/speech_frame_mouth_classifier_core.sv
// Top level: configuration registers, sample front end, frame queue and back end.
//
// Samples are taken one per cycle whenever the two-entry frame queue has room; a frame
// ends on frame_last or when its length reaches FRAME_MAX. Each frame then runs through
// a sequential back end (shared log2 unit, bit-serial rate divider, normalize, 31-step
// ratio divider and 16-step square root). Frames that arrive more slowly than the back
// end handles them stream at full rate; a run of frames that arrive faster holds in_stall
// high while the queue is full. One result per frame comes out through a registered
// output, and the back end starts on the next frame while a result waits.
`default_nettype none
module speech_frame_mouth_classifier_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_MAX   = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wr,
  input  wire logic [smc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [smc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample,
  input  wire logic                                   sample_bad,
  input  wire logic                                   frame_last,
  input  wire logic [31:0]                            timestamp_ms,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [15:0]                          level_db,
  output logic [16:0]                                 crossing_rate,
  output logic [15:0]                                 hf_ratio,
  output logic [1:0]                                  instant_state,
  output logic [1:0]                                  shown_state
);

  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam int EW = 2 * SAMPLE_BITS - 1 + CW;
  localparam int DW = 2 * SAMPLE_BITS + CW + 1;
  localparam int RW = EW + DW + 2 * CW + 32;

  smc_pkg::cfg_t cfg;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [RW-1:0] q_wdata;
  logic [RW-1:0] q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silence_level      <= smc_pkg::SILENCE_RESET;
      cfg.crossing_threshold <= smc_pkg::CROSSING_RESET;
      cfg.hf_threshold       <= smc_pkg::HF_RESET;
      cfg.hold_time_ms       <= smc_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        smc_pkg::REG_SILENCE:  cfg.silence_level      <= $signed(cfg_data[15:0]);
        smc_pkg::REG_CROSSING: cfg.crossing_threshold <= cfg_data;
        smc_pkg::REG_HF:       cfg.hf_threshold       <= cfg_data[15:0];
        smc_pkg::REG_HOLD:     cfg.hold_time_ms       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  smc_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAME_MAX  (FRAME_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .sample_bad  (sample_bad),
    .frame_last  (frame_last),
    .timestamp_ms(timestamp_ms),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  smc_fifo #(
    .WIDTH(RW),
    .DEPTH(2)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  smc_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAME_MAX  (FRAME_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_db     (level_db),
    .crossing_rate(crossing_rate),
    .hf_ratio     (hf_ratio),
    .instant_state(instant_state),
    .shown_state  (shown_state)
  );

endmodule
`default_nettype wire
